// File: hdl/scot_pkg.sv
package scot_pkg;

    // which point of the segment lies closest to the centre
    typedef enum logic [1:0] {
        CASE_NEAR = 2'd0,   // start point, or a zero-length segment
        CASE_FAR  = 2'd1,   // end point
        CASE_PROJ = 2'd2    // interior projection
    } t_seg_case;

    typedef struct packed {
        t_seg_case sel;
        logic      end_hit;   // verdict for CASE_NEAR / CASE_FAR
    } t_pre;

endpackage

// File: hdl/scot_wmul.sv
module scot_wmul #(
    parameter int W = 50
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output logic [2*W-1:0]   o_p
);
    localparam int H = W / 2;
    localparam int L = W - H;

    logic [2*L-1:0] r_hh;
    logic [2*L-1:0] r_hl;
    logic [2*L-1:0] r_lh;
    logic [2*L-1:0] r_ll;
    logic [2*W-1:0] r_p;
    logic [2*W-1:0] n_p;
    logic [2*L:0]   mid;

    // first stage: four half-width partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= (2*L)'(i_a[W-1:H]) * (2*L)'(i_b[W-1:H]);
            r_hl <= (2*L)'(i_a[W-1:H]) * (2*L)'(i_b[H-1:0]);
            r_lh <= (2*L)'(i_a[H-1:0]) * (2*L)'(i_b[W-1:H]);
            r_ll <= (2*L)'(i_a[H-1:0]) * (2*L)'(i_b[H-1:0]);
        end
    end

    always_comb begin
        mid = {1'b0, r_hl} + {1'b0, r_lh};
        n_p = (2*W)'({r_hh[2*L-1:0], r_ll[2*H-1:0]})
            + ((2*W)'(mid) << H);
    end

    // second stage: recombine
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// File: hdl/scot_front.sv
module scot_front #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic signed [COORD_BITS-1:0] i_centre_x,
    input  logic signed [COORD_BITS-1:0] i_centre_y,
    input  logic        [COORD_BITS-2:0] i_radius,
    output logic                         o_valid,
    output scot_pkg::t_pre               o_pre,
    output logic [2*COORD_BITS+1:0]      o_cr_mag,
    output logic [2*COORD_BITS+1:0]      o_vv,
    output logic [2*COORD_BITS+1:0]      o_r2
);
    import scot_pkg::*;

    localparam int D = COORD_BITS + 1;       // coordinate differences
    localparam int P = 2 * COORD_BITS + 2;   // products
    localparam int S = 2 * COORD_BITS + 3;   // sums of products
    localparam int R = COORD_BITS - 1;       // radius
    localparam int W = 2 * COORD_BITS + 2;   // magnitudes for the wide products

    // stage 1: differences
    logic                r_v1;
    logic signed [D-1:0] r_vx, r_vy, r_ux, r_uy, r_wx, r_wy;
    logic        [R-1:0] r_r1;

    // stage 2: products
    logic                  r_v2;
    logic signed [P-1:0]   r_vxvx, r_vyvy, r_vxux, r_vyuy, r_vxuy, r_vyux;
    logic signed [P-1:0]   r_uxux, r_uyuy, r_wxwx, r_wywy;
    logic        [2*R-1:0] r_r2_2;

    // stage 3: sums
    logic                  r_v3;
    logic signed [S-1:0]   r_vv, r_dot, r_cr, r_du, r_dw;
    logic        [2*R-1:0] r_r2_3;

    // stage 4: case selection and magnitudes
    logic                r_v4;
    t_pre                r_pre;
    logic [W-1:0]        r_cr_mag, r_vv4, r_r2_4;

    t_pre                n_pre;
    logic signed [S-1:0] r2_s;
    logic signed [S-1:0] cr_abs;
    logic                near_hit, far_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vx <= D'(i_end_x) - D'(i_start_x);
            r_vy <= D'(i_end_y) - D'(i_start_y);
            r_ux <= D'(i_centre_x) - D'(i_start_x);
            r_uy <= D'(i_centre_y) - D'(i_start_y);
            r_wx <= D'(i_centre_x) - D'(i_end_x);
            r_wy <= D'(i_centre_y) - D'(i_end_y);
            r_r1 <= i_radius;

            r_vxvx <= P'(r_vx) * P'(r_vx);
            r_vyvy <= P'(r_vy) * P'(r_vy);
            r_vxux <= P'(r_vx) * P'(r_ux);
            r_vyuy <= P'(r_vy) * P'(r_uy);
            r_vxuy <= P'(r_vx) * P'(r_uy);
            r_vyux <= P'(r_vy) * P'(r_ux);
            r_uxux <= P'(r_ux) * P'(r_ux);
            r_uyuy <= P'(r_uy) * P'(r_uy);
            r_wxwx <= P'(r_wx) * P'(r_wx);
            r_wywy <= P'(r_wy) * P'(r_wy);
            r_r2_2 <= (2*R)'(r_r1) * (2*R)'(r_r1);

            r_vv   <= S'(r_vxvx) + S'(r_vyvy);
            r_dot  <= S'(r_vxux) + S'(r_vyuy);
            r_cr   <= S'(r_vxuy) - S'(r_vyux);
            r_du   <= S'(r_uxux) + S'(r_uyuy);
            r_dw   <= S'(r_wxwx) + S'(r_wywy);
            r_r2_3 <= r_r2_2;

            r_pre    <= n_pre;
            r_cr_mag <= cr_abs[W-1:0];
            r_vv4    <= r_vv[W-1:0];
            r_r2_4   <= W'(r_r2_3);
        end
    end

    always_comb begin
        r2_s     = $signed(S'(r_r2_3));
        near_hit = r_du < r2_s;
        far_hit  = r_dw < r2_s;
        cr_abs   = r_cr[S-1] ? -r_cr : r_cr;
        // zero-length segment has a zero dot product, so it lands on the start point
        if (r_vv == '0 || r_dot[S-1] || r_dot == '0) begin
            n_pre.sel     = CASE_NEAR;
            n_pre.end_hit = near_hit;
        end else if (r_dot >= r_vv) begin
            n_pre.sel     = CASE_FAR;
            n_pre.end_hit = far_hit;
        end else begin
            n_pre.sel     = CASE_PROJ;
            n_pre.end_hit = 1'b0;
        end
    end

    assign o_valid  = r_v4;
    assign o_pre    = r_pre;
    assign o_cr_mag = r_cr_mag;
    assign o_vv     = r_vv4;
    assign o_r2     = r_r2_4;

endmodule

// File: hdl/segment_circle_occlusion_test.sv
// Segment / circle occlusion test. Each input item carries a segment A-B and a
// circle (centre, radius) in signed fixed point with 8 fractional bits; the
// result item says whether the point of the segment closest to the centre lies
// strictly inside the circle (touching gives 0, a zero-length segment is tested
// as its start point). The test is exact: the interior case compares
// cross(AB, AC)^2 against r^2 * |AB|^2 with no division. The pipeline takes
// one item per clock while its output slot is free or being taken; it is four
// stages of differences, products, sums and end-point selection, then the two
// split wide multipliers, each two stages, then the verdict register. When the
// result is not taken the whole pipeline holds, so nothing is lost or repeated.
module segment_circle_occlusion_test #(
    parameter int COORD_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // start_x, start_y, end_x, end_y, centre_x, centre_y, radius, zero pad
    input  logic [((7*COORD_BITS+6)/8)*8-1:0] i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // blocked, zero pad
    output logic [7:0]                     o_m_axis_tdata
);
    import scot_pkg::*;

    localparam int N = COORD_BITS;
    localparam int W = 2 * COORD_BITS + 2;

    logic         en;
    logic         f_valid;
    t_pre         f_pre;
    logic [W-1:0] f_cr_mag, f_vv, f_r2;
    logic [2*W-1:0] sq_cr, r2_vv;

    logic         r_v5, r_v6, r_out_valid;
    t_pre         r_pre5, r_pre6;
    logic         r_blocked;
    logic         n_blocked;

    // the whole pipeline advances whenever the output slot is free or being taken
    assign en = !r_out_valid || i_m_axis_tready;

    scot_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_s_axis_tvalid),
        .i_start_x  ($signed(i_s_axis_tdata[N-1:0])),
        .i_start_y  ($signed(i_s_axis_tdata[2*N-1:N])),
        .i_end_x    ($signed(i_s_axis_tdata[3*N-1:2*N])),
        .i_end_y    ($signed(i_s_axis_tdata[4*N-1:3*N])),
        .i_centre_x ($signed(i_s_axis_tdata[5*N-1:4*N])),
        .i_centre_y ($signed(i_s_axis_tdata[6*N-1:5*N])),
        .i_radius   (i_s_axis_tdata[7*N-2:6*N]),
        .o_valid    (f_valid),
        .o_pre      (f_pre),
        .o_cr_mag   (f_cr_mag),
        .o_vv       (f_vv),
        .o_r2       (f_r2)
    );

    scot_wmul #(
        .W(W)
    ) u_mul_cr (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (f_cr_mag),
        .i_b   (f_cr_mag),
        .o_p   (sq_cr)
    );

    scot_wmul #(
        .W(W)
    ) u_mul_rv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (f_r2),
        .i_b   (f_vv),
        .o_p   (r2_vv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v5        <= f_valid;
            r_v6        <= r_v5;
            r_out_valid <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pre5    <= f_pre;
            r_pre6    <= r_pre5;
            r_blocked <= n_blocked;
        end
    end

    always_comb begin
        case (r_pre6.sel)
            CASE_PROJ: n_blocked = sq_cr < r2_vv;
            default:   n_blocked = r_pre6.end_hit;
        endcase
    end

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_blocked};

endmodule
